// File: hdl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants for the framed message receiver: item structs,
// parser phases, result kinds and framing constants.
// ----------------------------------------------------------------------------
package fmr_pkg;

  // Framing constants
  localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND = 8'h62;
  localparam int unsigned LIMIT_W     = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

  // Result kinds
  localparam logic [1:0] KIND_BODY    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3,
    PH_CKA    = 3'd4,
    PH_CKB    = 3'd5
  } phase_e;

  // Input item
  typedef struct packed {
    logic       has_byte;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] body_length;
    logic [7:0]  body_data;
    logic [15:0] body_index;
    logic        checksum_ok;
    logic        last_of_frame;
  } out_item_t;

endpackage

// File: hdl/fmr_in_reg.sv
// ----------------------------------------------------------------------------
// fmr_in_reg
// Input register: holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
module fmr_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fmr_pkg::in_item_t in_item_i,
  input  logic             take_i,
  output logic             item_valid_o,
  output fmr_pkg::in_item_t item_o
);
  import fmr_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hdl/fmr_parse.sv
// ----------------------------------------------------------------------------
// fmr_parse
// Frame parser: sync hunt, header capture, body pass-through, Fletcher sum,
// checksum compare and attempt timeout. Updates state once per item.
// ----------------------------------------------------------------------------
module fmr_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  fmr_pkg::in_item_t        item_i,
  input  logic                     cfg_valid_i,
  input  logic [fmr_pkg::LIMIT_W-1:0] cfg_data_i,
  output logic                     res_valid_o,
  output fmr_pkg::out_item_t       res_o
);
  import fmr_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  phase_e             phase_q, phase_d;
  logic [1:0]         hdr_cnt_q, hdr_cnt_d;
  logic [7:0]         class_q, class_d;
  logic [7:0]         id_q, id_d;
  logic [15:0]        length_q, length_d;
  logic [16:0]        body_cnt_q, body_cnt_d;
  logic [7:0]         sum_a_q, sum_a_d;
  logic [7:0]         sum_b_q, sum_b_d;
  logic [7:0]         recv_a_q, recv_a_d;
  logic [LIMIT_W-1:0] attempt_q, attempt_d;

  logic               body_out;
  logic               frame_end;
  logic               ck_ok;
  logic               timeout;
  logic [LIMIT_W-1:0] attempt_inc;
  logic [7:0]         b;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    class_d     = class_q;
    id_d        = id_q;
    length_d    = length_q;
    body_cnt_d  = body_cnt_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    recv_a_d    = recv_a_q;
    attempt_d   = attempt_q;
    body_out    = 1'b0;
    frame_end   = 1'b0;
    ck_ok       = 1'b0;
    timeout     = 1'b0;
    attempt_inc = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    b           = item_i.rx_byte;

    if (fire_i) begin
      // Byte handling per phase
      if (item_i.has_byte) begin
        unique case (phase_q)
          PH_SYNC1: begin
            if (b == SYNC_FIRST) begin
              phase_d = PH_SYNC2;
            end
          end
          PH_SYNC2: begin
            phase_d   = (b == SYNC_SECOND) ? PH_HEADER : PH_SYNC1;
            hdr_cnt_d = '0;
          end
          PH_HEADER: begin
            sum_a_d = sum_a_q + b;
            sum_b_d = sum_b_q + sum_a_d;
            unique case (hdr_cnt_q)
              2'd0:    class_d = b;
              2'd1:    id_d = b;
              2'd2:    length_d = {length_q[15:8], b};
              default: length_d = {b, length_q[7:0]};
            endcase
            if (hdr_cnt_q == 2'd3) begin
              hdr_cnt_d  = '0;
              body_cnt_d = '0;
              phase_d    = (length_d == 16'd0) ? PH_CKA : PH_BODY;
            end else begin
              hdr_cnt_d = hdr_cnt_q + 2'd1;
            end
          end
          PH_BODY: begin
            sum_a_d    = sum_a_q + b;
            sum_b_d    = sum_b_q + sum_a_d;
            body_out   = 1'b1;
            body_cnt_d = body_cnt_q + 17'd1;
            if (body_cnt_d >= {1'b0, length_q}) begin
              phase_d = PH_CKA;
            end
          end
          PH_CKA: begin
            recv_a_d = b;
            phase_d  = PH_CKB;
          end
          PH_CKB: begin
            frame_end = 1'b1;
            ck_ok     = (recv_a_q == sum_a_q) && (b == sum_b_q);
          end
          default: begin
            phase_d    = PH_SYNC1;
            hdr_cnt_d  = '0;
            class_d    = '0;
            id_d       = '0;
            length_d   = '0;
            body_cnt_d = '0;
            sum_a_d    = '0;
            sum_b_d    = '0;
            recv_a_d   = '0;
            attempt_d  = '0;
          end
        endcase
      end

      // Count the attempt
      attempt_inc = attempt_d + 1'b1;
      timeout     = !frame_end &&
                    ((attempt_inc >= limit_q) || (attempt_inc == '0));

      // Build the result from the updated header registers
      res_o.msg_class   = class_d;
      res_o.msg_id      = id_d;
      res_o.body_length = length_d;
      if (frame_end) begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = KIND_END;
        res_o.checksum_ok   = ck_ok;
        res_o.last_of_frame = 1'b1;
      end else if (timeout) begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = KIND_TIMEOUT;
        res_o.last_of_frame = 1'b1;
      end else if (body_out) begin
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_BODY;
        res_o.body_data   = b;
        res_o.body_index  = body_cnt_q[15:0];
      end

      // Restart after frame end or timeout
      if (frame_end || timeout) begin
        phase_d    = PH_SYNC1;
        hdr_cnt_d  = '0;
        class_d    = '0;
        id_d       = '0;
        length_d   = '0;
        body_cnt_d = '0;
        sum_a_d    = '0;
        sum_b_d    = '0;
        recv_a_d   = '0;
        attempt_d  = '0;
      end else begin
        attempt_d = attempt_inc;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      hdr_cnt_q  <= '0;
      class_q    <= '0;
      id_q       <= '0;
      length_q   <= '0;
      body_cnt_q <= '0;
      sum_a_q    <= '0;
      sum_b_q    <= '0;
      recv_a_q   <= '0;
      attempt_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      class_q    <= class_d;
      id_q       <= id_d;
      length_q   <= length_d;
      body_cnt_q <= body_cnt_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      recv_a_q   <= recv_a_d;
      attempt_q  <= attempt_d;
    end
  end

endmodule

// File: hdl/fmr_out_reg.sv
// ----------------------------------------------------------------------------
// fmr_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module fmr_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fmr_pkg::out_item_t res_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fmr_pkg::out_item_t out_item_o
);
  import fmr_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // Free when empty or when the held item is taken this cycle
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // Capture result
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      item_q <= res_i;
    end
  end

endmodule

// File: hdl/framed_message_receiver.sv
// ----------------------------------------------------------------------------
// framed_message_receiver
// Usage: feed one item per handshake on the in channel: a received serial
// byte (has_byte = 1) or an idle tick (has_byte = 0). The block hunts for
// the sync pair, captures class, id and length, and emits one result item
// per body byte, one frame-end item with the checksum verdict, or one
// timeout item when attempt_limit items pass without a complete frame.
// Items that produce no result are consumed silently.
// Each accepted item passes from the input register to the parser, whose
// result the result register captures and shows on out_valid_o.
// Throughput: one item per cycle while the result register has space,
// set by the parser, which updates its state once per item.
// Stalls: when out_ready_i is low with a result held, the parser and the
// input register hold and in_ready_o drops once the input register is full.
// Reset: parser returns to sync hunt, counters and sums clear, attempt_limit
// returns to 100000, both registers empty. Write attempt_limit through the
// cfg channel only while the block is idle; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module framed_message_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fmr_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fmr_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fmr_pkg::LIMIT_W-1:0] cfg_data_i
);
  import fmr_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      space;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready_o = 1'b1;

  // Advance the held item when the result register can take its result
  assign fire = item_valid && space;

  fmr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .take_i       (space),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fmr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fmr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
